// ===== rtl/dat_pkg.sv =====
// Shared types, constants and a helper function for the device allocation table.
package dat_pkg;

    localparam int NUM_DEVICES = 16;
    localparam int NUM_TYPES   = 4;
    localparam int TYPE_SLOTS  = 4;
    localparam int REG_COUNT   = 4;

    localparam int REG_W     = 5;
    localparam int JOB_W     = 8;
    localparam int TYPE_W    = 2;
    localparam int MAP_W     = 16;
    localparam int STATUS_W  = 2;
    localparam int IDX_W     = $clog2(NUM_DEVICES);
    localparam int CNT_W     = $clog2(NUM_DEVICES + 1);
    localparam int CFG_IDX_W = $clog2(REG_COUNT);

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RECLAIM = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_SHORT = 2'd1,
        STATUS_NONE  = 2'd2
    } status_t;

    typedef logic [TYPE_SLOTS-1:0][REG_W-1:0] unit_vec_t;
    typedef logic [TYPE_SLOTS-1:0][CNT_W-1:0] cnt_vec_t;

    typedef struct packed {
        cnt_vec_t lo;
        cnt_vec_t hi;
    } ranges_t;

    // Request token that walks down the row of device cells.
    typedef struct packed {
        logic                   valid;
        logic                   mode;
        logic [JOB_W-1:0]       job;
        logic [CNT_W-1:0]       lo;
        logic [CNT_W-1:0]       hi;
        logic [CNT_W-1:0]       want;
        logic [CNT_W-1:0]       changed;
        logic [NUM_DEVICES-1:0] map;
    } pkt_t;

    localparam unit_vec_t RESET_UNITS = {REG_W'(1), REG_W'(4), REG_W'(3), REG_W'(2)};

    // Contiguous ranges per type, clipped at the end of the table.
    function automatic ranges_t build_ranges(input unit_vec_t units);
        ranges_t r;
        int      pos;
        int      c;
        pos = 0;
        for (int t = 0; t < TYPE_SLOTS; t++)
        begin
            c = (t < NUM_TYPES) ? int'(units[t]) : 0;
            if (c > NUM_DEVICES - pos)
                c = NUM_DEVICES - pos;
            r.lo[t] = CNT_W'(pos);
            r.hi[t] = CNT_W'(pos + c);
            pos     = pos + c;
        end
        return r;
    endfunction

endpackage

// ===== rtl/dat_req_if.sv =====
// Request channel: valid/ready handshake with the allocate or reclaim payload.
interface dat_req_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [dat_pkg::JOB_W-1:0]     job_id;
    logic [dat_pkg::TYPE_W-1:0]    device_type;
    logic [dat_pkg::REG_W-1:0]     unit_count;

    modport source (output valid, mode, job_id, device_type, unit_count, input ready);
    modport sink   (input valid, mode, job_id, device_type, unit_count, output ready);
endinterface

// ===== rtl/dat_rsp_if.sv =====
// Result channel: valid/ready handshake with status, device map and counts.
interface dat_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [dat_pkg::STATUS_W-1:0]  status;
    logic [dat_pkg::MAP_W-1:0]     device_map;
    logic [dat_pkg::REG_W-1:0]     units_changed;
    logic [dat_pkg::REG_W-1:0]     free_left;

    modport source (output valid, status, device_map, units_changed, free_left, input ready);
    modport sink   (input valid, status, device_map, units_changed, free_left, output ready);
endinterface

// ===== rtl/dat_cell.sv =====
// One device entry: busy flag and owner, updates the passing request token.
module dat_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clear,
    input  logic [dat_pkg::IDX_W-1:0]  idx,
    input  dat_pkg::pkt_t              pkt_in,
    output dat_pkg::pkt_t              pkt_out
);

    logic                       busy_reg;
    logic [dat_pkg::JOB_W-1:0]  owner_reg;
    dat_pkg::pkt_t              pkt_reg;
    dat_pkg::pkt_t              pkt_next;
    logic                       in_range;
    logic                       take;

    always_comb
    begin
        in_range = (dat_pkg::CNT_W'(idx) >= pkt_in.lo) && (dat_pkg::CNT_W'(idx) < pkt_in.hi);
        if (pkt_in.mode == dat_pkg::MODE_ALLOC)
            take = pkt_in.valid && in_range && !busy_reg && (pkt_in.changed < pkt_in.want);
        else
            take = pkt_in.valid && busy_reg && (owner_reg == pkt_in.job);

        pkt_next = pkt_in;
        if (take)
        begin
            pkt_next.changed  = pkt_in.changed + dat_pkg::CNT_W'(1);
            pkt_next.map[idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pkt_reg  <= '0;
        end
        else
        begin
            pkt_reg <= pkt_next;
            if (clear)
                busy_reg <= 1'b0;
            else if (take)
                busy_reg <= (pkt_in.mode == dat_pkg::MODE_ALLOC);
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && pkt_in.mode == dat_pkg::MODE_ALLOC)
            owner_reg <= pkt_in.job;
    end

    assign pkt_out = pkt_reg;

endmodule

// ===== rtl/dat_ctrl.sv =====
// Request sequencer: configuration, type ranges, free counts and result register.
module dat_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [dat_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dat_pkg::REG_W-1:0]     cfg_data,
    dat_req_if.sink                       req,
    dat_rsp_if.source                     rsp,
    output dat_pkg::pkt_t                 pkt_out,
    input  dat_pkg::pkt_t                 pkt_ret,
    output logic                          clear
);

    typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_DONE} state_t;

    state_t                                state_reg;
    dat_pkg::unit_vec_t                    units_reg;
    dat_pkg::unit_vec_t                    units_next;
    dat_pkg::ranges_t                      ranges_next;
    dat_pkg::ranges_t                      ranges_rst;
    dat_pkg::cnt_vec_t                     lo_reg;
    dat_pkg::cnt_vec_t                     hi_reg;
    dat_pkg::cnt_vec_t                     fc_reg;
    dat_pkg::cnt_vec_t                     fc_next;
    dat_pkg::pkt_t                         pkt_reg;

    logic                                  mode_reg;
    logic [dat_pkg::TYPE_W-1:0]            ty_reg;
    logic                                  fail_reg;
    logic [dat_pkg::NUM_DEVICES-1:0]       fin_map_reg;
    logic [dat_pkg::CNT_W-1:0]             fin_changed_reg;

    logic                                  rsp_valid_reg;
    logic [dat_pkg::STATUS_W-1:0]          status_reg;
    logic [dat_pkg::MAP_W-1:0]             map_reg;
    logic [dat_pkg::REG_W-1:0]             changed_reg;
    logic [dat_pkg::REG_W-1:0]             free_reg;

    logic [dat_pkg::CNT_W-1:0]             avail;
    logic                                  want_big;
    logic                                  want_zero;
    logic [dat_pkg::TYPE_SLOTS-1:0][dat_pkg::NUM_DEVICES-1:0] type_mask;
    dat_pkg::status_t                      status_sel;
    logic [dat_pkg::CNT_W-1:0]             free_sel;

    assign clear      = cfg_we && (int'(cfg_index) < dat_pkg::REG_COUNT);
    assign ranges_rst = dat_pkg::build_ranges(dat_pkg::RESET_UNITS);

    always_comb
    begin
        units_next = units_reg;
        if (clear)
            units_next[cfg_index] = cfg_data;
        ranges_next = dat_pkg::build_ranges(units_next);
    end

    always_comb
    begin
        avail     = (int'(req.device_type) < dat_pkg::NUM_TYPES) ? fc_reg[req.device_type] : '0;
        want_big  = int'(req.unit_count) > int'(avail);
        want_zero = (req.unit_count == '0);
    end

    // Device membership per type, used to return freed devices to their type.
    always_comb
    begin
        for (int t = 0; t < dat_pkg::TYPE_SLOTS; t++)
            for (int d = 0; d < dat_pkg::NUM_DEVICES; d++)
                type_mask[t][d] = (dat_pkg::CNT_W'(d) >= lo_reg[t]) &&
                                  (dat_pkg::CNT_W'(d) < hi_reg[t]);
    end

    always_comb
    begin
        fc_next = fc_reg;
        if (mode_reg == dat_pkg::MODE_ALLOC)
        begin
            if (!fail_reg)
                fc_next[ty_reg] = fc_reg[ty_reg] - fin_changed_reg;
            status_sel = fail_reg ? dat_pkg::STATUS_SHORT : dat_pkg::STATUS_OK;
        end
        else
        begin
            for (int t = 0; t < dat_pkg::TYPE_SLOTS; t++)
                fc_next[t] = fc_reg[t] +
                             dat_pkg::CNT_W'($countones(fin_map_reg & type_mask[t]));
            status_sel = (fin_changed_reg == '0) ? dat_pkg::STATUS_NONE : dat_pkg::STATUS_OK;
        end
        free_sel = (int'(ty_reg) < dat_pkg::NUM_TYPES) ? fc_next[ty_reg] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            units_reg       <= dat_pkg::RESET_UNITS;
            lo_reg          <= ranges_rst.lo;
            hi_reg          <= ranges_rst.hi;
            for (int t = 0; t < dat_pkg::TYPE_SLOTS; t++)
                fc_reg[t] <= ranges_rst.hi[t] - ranges_rst.lo[t];
            pkt_reg         <= '0;
            rsp_valid_reg   <= 1'b0;
            mode_reg        <= dat_pkg::MODE_ALLOC;
            ty_reg          <= '0;
            fail_reg        <= 1'b0;
            fin_map_reg     <= '0;
            fin_changed_reg <= '0;
            status_reg      <= '0;
            map_reg         <= '0;
            changed_reg     <= '0;
            free_reg        <= '0;
        end
        else
        begin
            if (rsp_valid_reg && rsp.ready && state_reg != ST_DONE)
                rsp_valid_reg <= 1'b0;

            if (clear)
            begin
                units_reg <= units_next;
                lo_reg    <= ranges_next.lo;
                hi_reg    <= ranges_next.hi;
                for (int t = 0; t < dat_pkg::TYPE_SLOTS; t++)
                    fc_reg[t] <= ranges_next.hi[t] - ranges_next.lo[t];
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        mode_reg        <= req.mode;
                        ty_reg          <= req.device_type;
                        fail_reg        <= (req.mode == dat_pkg::MODE_ALLOC) && want_big;
                        fin_map_reg     <= '0;
                        fin_changed_reg <= '0;
                        // Failed or empty allocations skip the sweep.
                        if (req.mode == dat_pkg::MODE_ALLOC && (want_big || want_zero))
                            state_reg <= ST_DONE;
                        else
                        begin
                            pkt_reg.valid   <= 1'b1;
                            pkt_reg.mode    <= req.mode;
                            pkt_reg.job     <= req.job_id;
                            pkt_reg.lo      <= lo_reg[req.device_type];
                            pkt_reg.hi      <= hi_reg[req.device_type];
                            pkt_reg.want    <= dat_pkg::CNT_W'(req.unit_count);
                            pkt_reg.changed <= '0;
                            pkt_reg.map     <= '0;
                            state_reg       <= ST_SWEEP;
                        end
                    end
                end
                ST_SWEEP:
                begin
                    // token is launched for a single cycle
                    pkt_reg.valid <= 1'b0;
                    if (pkt_ret.valid)
                    begin
                        fin_map_reg     <= pkt_ret.map;
                        fin_changed_reg <= pkt_ret.changed;
                        state_reg       <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_valid_reg <= 1'b1;
                        status_reg    <= status_sel;
                        map_reg       <= dat_pkg::MAP_W'(fin_map_reg);
                        changed_reg   <= dat_pkg::REG_W'(fin_changed_reg);
                        free_reg      <= dat_pkg::REG_W'(free_sel);
                        if (!clear)
                            fc_reg <= fc_next;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign req.ready         = (state_reg == ST_IDLE);
    assign pkt_out           = pkt_reg;
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.device_map    = map_reg;
    assign rsp.units_changed = changed_reg;
    assign rsp.free_left     = free_reg;

endmodule

// ===== rtl/device_allocation_table.sv =====
// Top level of the device allocation table: sequencer plus a row of device cells.
//
// Requests arrive on req (valid/ready). An allocate transaction claims the lowest
// free devices of one type for a job; a reclaim transaction frees every device of
// a job. Each request gives exactly one transaction on rsp with status, device
// map, number of devices changed and the type's remaining free count.
// A request that sweeps the table sends a token through sixteen device cells, one
// cell per cycle, and the sequencer registers the result when the token returns. An allocate
// that fails or asks for zero devices skips the sweep and goes straight to the
// done state. One request is in flight at a time; req.ready is high only
// while the sequencer is idle, and a new request is taken while the previous
// result still waits.
// If rsp stalls, the finished result holds and the next one waits in the
// sequencer until the output register frees.
// Reset, or any write to a count register (cfg_we), rebuilds the type ranges
// and marks every device free. Counts that pass the table's end are clipped.
module device_allocation_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [dat_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dat_pkg::REG_W-1:0]     cfg_data,
    dat_req_if.sink                       req,
    dat_rsp_if.source                     rsp
);

    dat_pkg::pkt_t pkt [dat_pkg::NUM_DEVICES+1];
    logic          clear;

    dat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp),
        .pkt_out   (pkt[0]),
        .pkt_ret   (pkt[dat_pkg::NUM_DEVICES]),
        .clear     (clear)
    );

    for (genvar i = 0; i < dat_pkg::NUM_DEVICES; i++)
    begin : g_cell
        dat_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .clear   (clear),
            .idx     (dat_pkg::IDX_W'(i)),
            .pkt_in  (pkt[i]),
            .pkt_out (pkt[i+1])
        );
    end

endmodule

// ===== bench/device_allocation_table_test.sv =====
// Self-checking testbench for the device allocation table: random and directed requests.
module device_allocation_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic                       mode;
        logic [dat_pkg::JOB_W-1:0]  job;
        logic [dat_pkg::TYPE_W-1:0] dtype;
        logic [dat_pkg::REG_W-1:0]  count;
        bit                         settle;   // hold off until every outstanding result is back
    } request_t;

    typedef struct {
        dat_pkg::status_t           status;
        logic [dat_pkg::MAP_W-1:0]  map;
        logic [dat_pkg::REG_W-1:0]  changed;
        logic [dat_pkg::REG_W-1:0]  free_left;
    } outcome_t;

    typedef enum int {READY_ALWAYS, READY_COIN, READY_PATTERN, READY_SPARSE} ready_style_t;

    localparam int PHASES       = 9;
    localparam int RANDOM_ITEMS = 78;
    localparam int SHOWN_ERRORS = 10;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [dat_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [dat_pkg::REG_W-1:0]     cfg_data;

    dat_req_if req();
    dat_rsp_if rsp();

    device_allocation_table i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp)
    );

    // Table model
    logic [dat_pkg::REG_W-1:0] unit_reg  [dat_pkg::TYPE_SLOTS];
    int                        range_lo  [dat_pkg::TYPE_SLOTS];
    int                        range_len [dat_pkg::TYPE_SLOTS];
    int                        free_cnt  [dat_pkg::TYPE_SLOTS];
    bit                        busy      [dat_pkg::NUM_DEVICES];
    logic [dat_pkg::JOB_W-1:0] owner     [dat_pkg::NUM_DEVICES];

    request_t pending_reqs[$];
    outcome_t expected_results[$];

    bit           req_taken;
    int           burst_left;
    int           gap_left;
    ready_style_t ready_style;
    int           style_left;
    logic [7:0]   ready_pat;

    int errors;
    int n_granted;
    int n_refused;
    int n_empty;
    int n_cfg_writes;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Ranges are packed in type order and clipped at the end of the table.
    function automatic void rebuild_table();
        int pos;
        int c;
        pos = 0;
        for (int t = 0; t < dat_pkg::TYPE_SLOTS; t++)
        begin
            c = (t < dat_pkg::NUM_TYPES) ? int'(unit_reg[t]) : 0;
            if (c > dat_pkg::NUM_DEVICES - pos)
                c = dat_pkg::NUM_DEVICES - pos;
            range_lo[t]  = pos;
            range_len[t] = c;
            free_cnt[t]  = c;
            pos          = pos + c;
        end
        for (int d = 0; d < dat_pkg::NUM_DEVICES; d++)
        begin
            busy[d]  = 1'b0;
            owner[d] = '0;
        end
    endfunction

    function automatic outcome_t apply_request(request_t r);
        outcome_t o;
        int       ty;
        int       want;
        o.status  = dat_pkg::STATUS_OK;
        o.map     = '0;
        o.changed = '0;
        ty        = int'(r.dtype);
        want      = int'(r.count);
        if (r.mode == dat_pkg::MODE_ALLOC)
        begin
            if (ty >= dat_pkg::NUM_TYPES || want > free_cnt[ty])
                o.status = (want > 0) ? dat_pkg::STATUS_SHORT : dat_pkg::STATUS_OK;
            else if (want > 0)
            begin
                for (int d = range_lo[ty];
                     d < range_lo[ty] + range_len[ty] && int'(o.changed) < want; d++)
                begin
                    if (!busy[d])
                    begin
                        busy[d]  = 1'b1;
                        owner[d] = r.job;
                        o.map[d] = 1'b1;
                        o.changed++;
                    end
                end
                free_cnt[ty] -= int'(o.changed);
            end
        end
        else
        begin
            // Frees across all types, not only the one named in the request.
            for (int d = 0; d < dat_pkg::NUM_DEVICES; d++)
            begin
                if (busy[d] && owner[d] == r.job)
                begin
                    busy[d]  = 1'b0;
                    owner[d] = '0;
                    o.map[d] = 1'b1;
                    o.changed++;
                    for (int t = 0; t < dat_pkg::TYPE_SLOTS; t++)
                        if (d >= range_lo[t] && d < range_lo[t] + range_len[t])
                            free_cnt[t]++;
                end
            end
            if (o.changed == 0)
                o.status = dat_pkg::STATUS_NONE;
        end
        o.free_left = (ty < dat_pkg::NUM_TYPES) ? dat_pkg::REG_W'(free_cnt[ty]) : '0;
        return o;
    endfunction

    function automatic void note_mismatch(string what);
        errors++;
        if (errors <= SHOWN_ERRORS)
            $display("[%0t] MISMATCH: %s", $realtime, what);
    endfunction

    // Monitor: register writes, accepted requests and accepted results
    always @(posedge clk)
    begin
        request_t r;
        outcome_t exp_o;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                unit_reg[cfg_index] = cfg_data;
                rebuild_table();
            end
            // result first, so a same-edge request cannot stand in for a missing one
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                    note_mismatch($sformatf("unexpected result status=%0d map=%h",
                                            rsp.status, rsp.device_map));
                else
                begin
                    exp_o = expected_results.pop_front();
                    if (rsp.status !== exp_o.status || rsp.device_map !== exp_o.map ||
                        rsp.units_changed !== exp_o.changed ||
                        rsp.free_left !== exp_o.free_left)
                        note_mismatch($sformatf(
                            "exp status=%0d map=%h changed=%0d free=%0d, got %0d %h %0d %0d",
                            exp_o.status, exp_o.map, exp_o.changed, exp_o.free_left,
                            rsp.status, rsp.device_map, rsp.units_changed, rsp.free_left));
                    case (exp_o.status)
                        dat_pkg::STATUS_OK:    n_granted++;
                        dat_pkg::STATUS_SHORT: n_refused++;
                        default:               n_empty++;
                    endcase
                end
            end
            if (req.valid && req.ready)
            begin
                r.mode   = req.mode;
                r.job    = req.job_id;
                r.dtype  = req.device_type;
                r.count  = req.unit_count;
                r.settle = 1'b0;
                expected_results.push_back(apply_request(r));
                req_taken = 1'b1;
            end
        end
    end

    // Request driver: bursts with gaps in between
    always @(negedge clk)
    begin
        request_t r;
        if (!rst_n)
            req.valid <= 1'b0;
        else if (!req.valid || req_taken)
        begin
            if (req_taken)
            begin
                req_taken = 1'b0;
                if (burst_left > 0)
                    burst_left--;
            end
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
            if (gap_left > 0)
            begin
                gap_left--;
                req.valid <= 1'b0;
            end
            else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].settle && expected_results.size() != 0))
            begin
                r = pending_reqs.pop_front();
                req.valid       <= 1'b1;
                req.mode        <= r.mode;
                req.job_id      <= r.job;
                req.device_type <= r.dtype;
                req.unit_count  <= r.count;
            end
            else
                req.valid <= 1'b0;
        end
    end

    // Result back-pressure
    always @(negedge clk)
    begin
        if (style_left == 0)
        begin
            ready_style = ready_style_t'($urandom_range(0, 3));
            style_left  = $urandom_range(20, 80);
            ready_pat   = 8'($urandom);
        end
        style_left--;
        case (ready_style)
            READY_ALWAYS:  rsp.ready <= 1'b1;
            READY_COIN:    rsp.ready <= 1'($urandom_range(0, 1));
            READY_PATTERN:
            begin
                rsp.ready <= ready_pat[0];
                ready_pat = {ready_pat[0], ready_pat[7:1]};
            end
            default:       rsp.ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    function automatic void queue_request(logic mode, int job, int dtype, int count,
                                          bit settle = 1'b0);
        request_t r;
        r.mode   = mode;
        r.job    = dat_pkg::JOB_W'(job);
        r.dtype  = dat_pkg::TYPE_W'(dtype);
        r.count  = dat_pkg::REG_W'(count);
        r.settle = settle;
        pending_reqs.push_back(r);
    endfunction

    // Mostly a small pool of jobs so reclaims find something to free.
    function automatic void queue_random_requests(int n);
        request_t r;
        int       pick;
        repeat (n)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 8)
                r.job = dat_pkg::JOB_W'($urandom_range(1, 6));
            else if (pick == 8)
                r.job = ($urandom_range(0, 1) == 0) ? dat_pkg::JOB_W'(0) :
                                                      dat_pkg::JOB_W'(255);
            else
                r.job = dat_pkg::JOB_W'($urandom_range(0, 255));
            r.mode  = ($urandom_range(0, 9) < 4) ? dat_pkg::MODE_RECLAIM : dat_pkg::MODE_ALLOC;
            r.dtype = dat_pkg::TYPE_W'($urandom_range(0, 3));
            pick    = $urandom_range(0, 19);
            if (pick < 14)
                r.count = dat_pkg::REG_W'($urandom_range(1, 3));
            else if (pick < 17)
                r.count = dat_pkg::REG_W'($urandom_range(0, 6));
            else
                r.count = dat_pkg::REG_W'($urandom_range(0, 31));
            r.settle = ($urandom_range(0, 59) == 0);
            pending_reqs.push_back(r);
        end
    endfunction

    task automatic write_units(int v0, int v1, int v2, int v3);
        int vals[dat_pkg::TYPE_SLOTS];
        vals = '{v0, v1, v2, v3};
        for (int i = 0; i < dat_pkg::REG_COUNT; i++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= dat_pkg::CFG_IDX_W'(i);
            cfg_data  <= dat_pkg::REG_W'(vals[i]);
            n_cfg_writes++;
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || req.valid || expected_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int unit_sets[PHASES][dat_pkg::TYPE_SLOTS];
        unit_sets = '{'{2, 3, 4, 1}, '{16, 0, 0, 0}, '{0, 0, 0, 16}, '{31, 31, 31, 31},
                      '{4, 4, 4, 4}, '{0, 5, 0, 11}, '{1, 1, 1, 1}, '{0, 0, 0, 0},
                      '{0, 0, 0, 0}};
        req.valid       = 1'b0;
        req.mode        = dat_pkg::MODE_ALLOC;
        req.job_id      = '0;
        req.device_type = '0;
        req.unit_count  = '0;
        rsp.ready       = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        rst_n           = 1'b0;
        for (int t = 0; t < dat_pkg::TYPE_SLOTS; t++)
            unit_reg[t] = dat_pkg::RESET_UNITS[t];
        rebuild_table();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == PHASES - 1)
                for (int t = 0; t < dat_pkg::TYPE_SLOTS; t++)
                    unit_sets[p][t] = $urandom_range(0, 31);
            if (p != 0)
                write_units(unit_sets[p][0], unit_sets[p][1], unit_sets[p][2],
                            unit_sets[p][3]);
            if (p == 0)
            begin
                // reset layout: input 0-1, printer 2-4, disk 5-8, tape 9
                queue_request(dat_pkg::MODE_ALLOC, 1, 0, 2);
                queue_request(dat_pkg::MODE_ALLOC, 2, 0, 1);        // type exhausted
                queue_request(dat_pkg::MODE_ALLOC, 3, 1, 0);        // zero count
                queue_request(dat_pkg::MODE_ALLOC, 0, 2, 3);        // job zero
                queue_request(dat_pkg::MODE_ALLOC, 255, 3, 1, 1'b1);
                queue_request(dat_pkg::MODE_ALLOC, 255, 3, 31);
                queue_request(dat_pkg::MODE_ALLOC, 4, 1, 16);
                queue_request(dat_pkg::MODE_RECLAIM, 1, 0, 0);
                queue_request(dat_pkg::MODE_RECLAIM, 1, 2, 0);      // holds nothing
                queue_request(dat_pkg::MODE_RECLAIM, 0, 3, 31);
                queue_request(dat_pkg::MODE_ALLOC, 5, 1, 3);
                queue_request(dat_pkg::MODE_ALLOC, 6, 2, 2);
                queue_request(dat_pkg::MODE_RECLAIM, 255, 3, 0);
                queue_request(dat_pkg::MODE_RECLAIM, 5, 1, 31);
            end
            else if (p == 1)
            begin
                // whole table is type 0
                queue_request(dat_pkg::MODE_ALLOC, 7, 0, 16);
                queue_request(dat_pkg::MODE_ALLOC, 8, 0, 1);
                queue_request(dat_pkg::MODE_ALLOC, 8, 2, 1);        // type with no devices
                queue_request(dat_pkg::MODE_ALLOC, 8, 3, 0);
                queue_request(dat_pkg::MODE_RECLAIM, 7, 0, 0, 1'b1);
                queue_request(dat_pkg::MODE_RECLAIM, 7, 1, 0);
            end
            queue_random_requests(RANDOM_ITEMS);
            wait_drained();
        end

        repeat (40) @(posedge clk);
        $display("Covered %0d requests over %0d table layouts (%0d register writes):",
                 n_granted + n_refused + n_empty, PHASES, n_cfg_writes);
        $display("  %0d completed, %0d refused for lack of devices, %0d reclaims of idle jobs",
                 n_granted, n_refused, n_empty);
        if (errors == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Timeout waiting for the table to drain");
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== device_allocation_table.f =====
rtl/dat_pkg.sv
rtl/dat_req_if.sv
rtl/dat_rsp_if.sv
rtl/dat_cell.sv
rtl/dat_ctrl.sv
rtl/device_allocation_table.sv
bench/device_allocation_table_test.sv
